### sv/gpid_pkg.sv
// Shared types, constants and codes of the gain-scheduled PID controller.
package gpid_pkg;

   // fixed point format of error, gains and clamps
   localparam int unsigned FRAC_BITS = 8;

   // gain scheduling breakpoints on |error|: 2.0 and 3.5
   localparam int unsigned MAG_LO = 2 << FRAC_BITS;
   localparam int unsigned MAG_HI = (7 << FRAC_BITS) >> 1;

   // field and register widths
   localparam int unsigned ERR_W   = 16;
   localparam int unsigned GAIN_W  = 16;
   localparam int unsigned CLAMP_W = 23;
   localparam int unsigned THR_W   = 15;
   localparam int unsigned SUM_W   = 24;
   localparam int unsigned DRIVE_W = 24;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 23;

   // shared multiplier: signed A times signed B
   localparam int unsigned MUL_A_W = 20;
   localparam int unsigned MUL_B_W = 25;
   localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

   // accumulator for P + I + D with 2*FRAC_BITS fraction bits
   localparam int unsigned ACC_W = 42;

   // interpolation: (|e| - 2.0) * delta / 1.5, with 1.5 = 3 * 2^(FRAC_BITS-1).
   // After the power-of-two part, the quotient by 3 uses a reciprocal.
   localparam int unsigned X_W         = 18;
   localparam int unsigned QUOT_W      = 16;
   localparam int unsigned RECIP_SHIFT = 20;
   localparam int unsigned RECIP_W     = 19;
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_SMALL        = 3'd0,
      CSR_KP_LARGE        = 3'd1,
      CSR_KI_GAIN         = 3'd2,
      CSR_KD_GAIN         = 3'd3,
      CSR_INTEGRAL_CLAMP  = 3'd4,
      CSR_OUTPUT_CLAMP    = 3'd5,
      CSR_INTEGRATE_BELOW = 3'd6
   } csr_index_type;

   // configuration reset values
   localparam logic [GAIN_W-1:0]  KP_SMALL_RST        = 16'd14080;
   localparam logic [GAIN_W-1:0]  KP_LARGE_RST        = 16'd23040;
   localparam logic [CLAMP_W-1:0] INTEGRAL_CLAMP_RST  = 23'd8388607;
   localparam logic [CLAMP_W-1:0] OUTPUT_CLAMP_RST    = 23'd8388607;
   localparam logic [THR_W-1:0]   INTEGRATE_BELOW_RST = 15'd32767;

   // request beat
   typedef struct packed {
      logic                    action;
      logic signed [ERR_W-1:0] error_in;
   } req_type;

   // response beat
   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      clamped;
   } rsp_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INTERP,
      ST_RECIP,
      ST_KP,
      ST_KI,
      ST_KD,
      ST_FINISH,
      ST_CLEAR
   } state_type;

   // multiplier passes
   typedef enum logic [2:0] {
      STEP_INTERP,
      STEP_RECIP,
      STEP_KP,
      STEP_KI,
      STEP_KD
   } step_type;

   // controller to datapath
   typedef struct packed {
      logic     load;
      logic     step_en;
      step_type step;
      logic     emit;
      logic     emit_zero;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

### sv/gpid_ctrl.sv
// Controller state machine sequencing the passes through the shared multiplier.
module gpid_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_action,
   output logic              req_stall,
   input  gpid_pkg::sts_type sts,
   output gpid_pkg::cmd_type cmd
);

   gpid_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gpid_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gpid_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = req_action ? gpid_pkg::ST_CLEAR : gpid_pkg::ST_INTERP;
            end
         end
         gpid_pkg::ST_INTERP: state_in = gpid_pkg::ST_RECIP;
         gpid_pkg::ST_RECIP:  state_in = gpid_pkg::ST_KP;
         gpid_pkg::ST_KP:     state_in = gpid_pkg::ST_KI;
         gpid_pkg::ST_KI:     state_in = gpid_pkg::ST_KD;
         gpid_pkg::ST_KD:     state_in = gpid_pkg::ST_FINISH;
         gpid_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               state_in = gpid_pkg::ST_IDLE;
            end
         end
         gpid_pkg::ST_CLEAR: begin
            if (sts.out_free) begin
               state_in = gpid_pkg::ST_IDLE;
            end
         end
         default: state_in = gpid_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall     = (state_ff != gpid_pkg::ST_IDLE);
      cmd.load      = 1'b0;
      cmd.step_en   = 1'b0;
      cmd.step      = gpid_pkg::STEP_INTERP;
      cmd.emit      = 1'b0;
      cmd.emit_zero = 1'b0;
      unique case (state_ff)
         gpid_pkg::ST_IDLE:   cmd.load = req_valid;
         gpid_pkg::ST_INTERP: begin
            cmd.step_en = 1'b1;
            cmd.step    = gpid_pkg::STEP_INTERP;
         end
         gpid_pkg::ST_RECIP: begin
            cmd.step_en = 1'b1;
            cmd.step    = gpid_pkg::STEP_RECIP;
         end
         gpid_pkg::ST_KP: begin
            cmd.step_en = 1'b1;
            cmd.step    = gpid_pkg::STEP_KP;
         end
         gpid_pkg::ST_KI: begin
            cmd.step_en = 1'b1;
            cmd.step    = gpid_pkg::STEP_KI;
         end
         gpid_pkg::ST_KD: begin
            cmd.step_en = 1'b1;
            cmd.step    = gpid_pkg::STEP_KD;
         end
         gpid_pkg::ST_FINISH: cmd.emit = sts.out_free;
         gpid_pkg::ST_CLEAR: begin
            cmd.emit      = sts.out_free;
            cmd.emit_zero = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

### sv/gpid_datapath.sv
// Datapath: configuration registers, controller state, shared multiplier and output register.
module gpid_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [gpid_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gpid_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  gpid_pkg::req_type                    req_data,
   input  gpid_pkg::cmd_type                    cmd,
   output gpid_pkg::sts_type                    sts,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output gpid_pkg::rsp_type                    rsp_data
);

   // configuration registers
   logic [gpid_pkg::GAIN_W-1:0]  kp_small_ff, kp_large_ff, ki_gain_ff, kd_gain_ff;
   logic [gpid_pkg::CLAMP_W-1:0] integral_clamp_ff, output_clamp_ff;
   logic [gpid_pkg::THR_W-1:0]   integrate_below_ff;

   // controller state
   logic signed [gpid_pkg::SUM_W-1:0] error_sum_ff, error_sum_in;
   logic signed [gpid_pkg::ERR_W-1:0] last_error_ff;

   // per-item working registers
   logic signed [gpid_pkg::ERR_W-1:0]   e_ff;
   logic        [gpid_pkg::ERR_W-1:0]   mag_ff;
   logic signed [gpid_pkg::ERR_W:0]     diff_ff;
   logic signed [gpid_pkg::MUL_P_W-1:0] prod_ff;
   logic        [gpid_pkg::QUOT_W-1:0]  q_ff;
   logic                                q_neg_ff;
   logic signed [gpid_pkg::ACC_W-1:0]   acc_ff, acc_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   gpid_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // multiplier
   logic signed [gpid_pkg::MUL_A_W-1:0] mul_a;
   logic signed [gpid_pkg::MUL_B_W-1:0] mul_b;
   logic signed [gpid_pkg::MUL_P_W-1:0] mul_p;

   logic        [gpid_pkg::MUL_A_W-1:0] mag_ext, mag_lo_ext, mag_hi_ext;
   logic signed [gpid_pkg::GAIN_W:0]    kp_delta, kp_q, kp_interp;
   logic        [gpid_pkg::GAIN_W-1:0]  kp_sel;
   logic signed [gpid_pkg::MUL_P_W-1:0] prod_abs;
   logic        [gpid_pkg::X_W-1:0]     recip_x;
   logic signed [gpid_pkg::SUM_W:0]     sum_wide, iclamp_s;
   logic signed [gpid_pkg::ERR_W:0]     diff_in;
   logic signed [gpid_pkg::ACC_W-1:0]   acc_shift, oclamp_s;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_small_ff        <= gpid_pkg::KP_SMALL_RST;
         kp_large_ff        <= gpid_pkg::KP_LARGE_RST;
         ki_gain_ff         <= '0;
         kd_gain_ff         <= '0;
         integral_clamp_ff  <= gpid_pkg::INTEGRAL_CLAMP_RST;
         output_clamp_ff    <= gpid_pkg::OUTPUT_CLAMP_RST;
         integrate_below_ff <= gpid_pkg::INTEGRATE_BELOW_RST;
      end else if (csr_write) begin
         unique case (gpid_pkg::csr_index_type'(csr_index))
            gpid_pkg::CSR_KP_SMALL:        kp_small_ff <= csr_wdata[gpid_pkg::GAIN_W-1:0];
            gpid_pkg::CSR_KP_LARGE:        kp_large_ff <= csr_wdata[gpid_pkg::GAIN_W-1:0];
            gpid_pkg::CSR_KI_GAIN:         ki_gain_ff  <= csr_wdata[gpid_pkg::GAIN_W-1:0];
            gpid_pkg::CSR_KD_GAIN:         kd_gain_ff  <= csr_wdata[gpid_pkg::GAIN_W-1:0];
            gpid_pkg::CSR_INTEGRAL_CLAMP:  integral_clamp_ff <= csr_wdata;
            gpid_pkg::CSR_OUTPUT_CLAMP:    output_clamp_ff   <= csr_wdata;
            gpid_pkg::CSR_INTEGRATE_BELOW:
               integrate_below_ff <= csr_wdata[gpid_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   // gain schedule and operand selection
   always_comb begin
      mag_ext    = {{(gpid_pkg::MUL_A_W-gpid_pkg::ERR_W){1'b0}}, mag_ff};
      mag_lo_ext = gpid_pkg::MUL_A_W'(gpid_pkg::MAG_LO);
      mag_hi_ext = gpid_pkg::MUL_A_W'(gpid_pkg::MAG_HI);
      kp_delta   = $signed({1'b0, kp_large_ff}) - $signed({1'b0, kp_small_ff});
      prod_abs   = prod_ff[gpid_pkg::MUL_P_W-1] ? -prod_ff : prod_ff;
      recip_x    = prod_abs[gpid_pkg::FRAC_BITS-1 +: gpid_pkg::X_W];
      kp_q       = q_neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      kp_interp  = $signed({1'b0, kp_small_ff}) + kp_q;
      if (mag_ext >= mag_hi_ext) begin
         kp_sel = kp_large_ff;
      end else if (mag_ext <= mag_lo_ext) begin
         kp_sel = kp_small_ff;
      end else begin
         kp_sel = kp_interp[gpid_pkg::GAIN_W-1:0];
      end

      unique case (cmd.step)
         gpid_pkg::STEP_INTERP: begin
            mul_a = $signed(mag_ext - mag_lo_ext);
            mul_b = {{(gpid_pkg::MUL_B_W-gpid_pkg::GAIN_W-1){kp_delta[gpid_pkg::GAIN_W]}},
                     kp_delta};
         end
         gpid_pkg::STEP_RECIP: begin
            mul_a = $signed({{(gpid_pkg::MUL_A_W-gpid_pkg::X_W){1'b0}}, recip_x});
            mul_b = $signed({{(gpid_pkg::MUL_B_W-gpid_pkg::RECIP_W){1'b0}},
                             gpid_pkg::RECIP_M});
         end
         gpid_pkg::STEP_KP: begin
            mul_a = $signed({{(gpid_pkg::MUL_A_W-gpid_pkg::GAIN_W){1'b0}}, kp_sel});
            mul_b = {{(gpid_pkg::MUL_B_W-gpid_pkg::ERR_W){e_ff[gpid_pkg::ERR_W-1]}}, e_ff};
         end
         gpid_pkg::STEP_KI: begin
            mul_a = $signed({{(gpid_pkg::MUL_A_W-gpid_pkg::GAIN_W){1'b0}}, ki_gain_ff});
            mul_b = {{(gpid_pkg::MUL_B_W-gpid_pkg::SUM_W){error_sum_ff[gpid_pkg::SUM_W-1]}},
                     error_sum_ff};
         end
         gpid_pkg::STEP_KD: begin
            mul_a = $signed({{(gpid_pkg::MUL_A_W-gpid_pkg::GAIN_W){1'b0}}, kd_gain_ff});
            mul_b = {{(gpid_pkg::MUL_B_W-gpid_pkg::ERR_W-1){diff_ff[gpid_pkg::ERR_W]}},
                     diff_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // integral with separation and clamp
   always_comb begin
      sum_wide = {error_sum_ff[gpid_pkg::SUM_W-1], error_sum_ff};
      if ({1'b0, mag_ff} < {2'b00, integrate_below_ff}) begin
         sum_wide = sum_wide
                  + {{(gpid_pkg::SUM_W+1-gpid_pkg::ERR_W){e_ff[gpid_pkg::ERR_W-1]}}, e_ff};
      end
      iclamp_s = $signed({2'b00, integral_clamp_ff});
      if (sum_wide > iclamp_s) begin
         sum_wide = iclamp_s;
      end else if (sum_wide < -iclamp_s) begin
         sum_wide = -iclamp_s;
      end
      error_sum_in = sum_wide[gpid_pkg::SUM_W-1:0];
   end

   // accumulate P + I + D
   always_comb begin
      acc_in = acc_ff;
      if (cmd.step_en) begin
         unique case (cmd.step)
            gpid_pkg::STEP_KP: acc_in = mul_p[gpid_pkg::ACC_W-1:0];
            gpid_pkg::STEP_KI,
            gpid_pkg::STEP_KD: acc_in = acc_ff + mul_p[gpid_pkg::ACC_W-1:0];
            default: ;
         endcase
      end
   end

   // floor shift, output clamp and the output register's next value
   always_comb begin
      acc_shift   = acc_ff >>> gpid_pkg::FRAC_BITS;
      oclamp_s    = $signed({{(gpid_pkg::ACC_W-gpid_pkg::CLAMP_W){1'b0}}, output_clamp_ff});
      rsp_data_in = rsp_data_ff;
      if (cmd.emit) begin
         if (cmd.emit_zero) begin
            rsp_data_in.drive   = '0;
            rsp_data_in.clamped = 1'b0;
         end else if (acc_shift > oclamp_s) begin
            rsp_data_in.drive   = oclamp_s[gpid_pkg::DRIVE_W-1:0];
            rsp_data_in.clamped = 1'b1;
         end else if (acc_shift < -oclamp_s) begin
            rsp_data_in.drive   = -oclamp_s[gpid_pkg::DRIVE_W-1:0];
            rsp_data_in.clamped = 1'b1;
         end else begin
            rsp_data_in.drive   = acc_shift[gpid_pkg::DRIVE_W-1:0];
            rsp_data_in.clamped = 1'b0;
         end
      end
      rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);
   end

   assign diff_in = $signed({req_data.error_in[gpid_pkg::ERR_W-1], req_data.error_in})
                  - $signed({last_error_ff[gpid_pkg::ERR_W-1], last_error_ff});

   // controller state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load) begin
            if (req_data.action) begin
               error_sum_ff  <= '0;
               last_error_ff <= '0;
            end else begin
               last_error_ff <= req_data.error_in;
            end
         end
         if (cmd.step_en && cmd.step == gpid_pkg::STEP_INTERP) begin
            error_sum_ff <= error_sum_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      acc_ff      <= acc_in;
      if (cmd.load) begin
         e_ff    <= req_data.error_in;
         mag_ff  <= req_data.error_in[gpid_pkg::ERR_W-1] ? -req_data.error_in
                                                          : req_data.error_in;
         diff_ff <= diff_in;
      end
      if (cmd.step_en && cmd.step == gpid_pkg::STEP_INTERP) begin
         prod_ff <= mul_p;
      end
      if (cmd.step_en && cmd.step == gpid_pkg::STEP_RECIP) begin
         q_ff     <= mul_p[gpid_pkg::RECIP_SHIFT +: gpid_pkg::QUOT_W];
         q_neg_ff <= prod_ff[gpid_pkg::MUL_P_W-1];
      end
   end

   assign sts.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

### sv/gain_scheduled_pid_unit.sv
// Gain-scheduled PID controller with integral separation: controller plus datapath.
// One request beat carries a signed Q8.8 error (or a clear action); one response beat
// carries the saturated Q16.8 drive and a clamped flag. A compute beat, once taken,
// makes five passes through the single shared multiplier (gain interpolation,
// reciprocal divide by 1.5, Kp, Ki and Kd terms); the finish state rounds and clamps
// the result into the output register. A clear beat goes from idle to the clear state,
// which writes a zero response. The response sits in an output register, so a new
// request is taken while the previous response waits; a stalled response holds the
// block only when the next one is ready. Configuration registers are to be written
// only while the block is idle; the block itself does not enforce this.
module gain_scheduled_pid_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [gpid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gpid_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gpid_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gpid_pkg::rsp_type               rsp_data
);

   gpid_pkg::cmd_type cmd;
   gpid_pkg::sts_type sts;

   // sequencer
   gpid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // arithmetic and storage
   gpid_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/gain_scheduled_pid_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the gain-scheduled PID unit: directed cases, backpressure, random.
module gain_scheduled_pid_unit_tb;

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned PHASE_BEATS   = 150;
   localparam int unsigned PHASE_COUNT   = 8;
   localparam int unsigned HOLD_OFF_LEN  = 300;

   // action codes of a request beat
   localparam logic ACT_STEP  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // index past the last register, writes there are dropped
   localparam logic [gpid_pkg::CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   localparam logic [gpid_pkg::GAIN_W-1:0]  GAIN_MAX  = '1;
   localparam logic [gpid_pkg::CLAMP_W-1:0] CLAMP_MAX = '1;
   localparam logic [gpid_pkg::THR_W-1:0]   THR_MAX   = '1;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write;
   logic [gpid_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [gpid_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                            req_valid;
   logic                            req_stall;
   gpid_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   gpid_pkg::rsp_type               rsp_data;

   // local copy of the registers and the controller state
   logic [gpid_pkg::GAIN_W-1:0]  kp_small_q, kp_large_q, ki_gain_q, kd_gain_q;
   logic [gpid_pkg::CLAMP_W-1:0] integral_clamp_q, output_clamp_q;
   logic [gpid_pkg::THR_W-1:0]   integrate_below_q;
   longint                       integral_acc;
   longint                       held_error;

   gpid_pkg::rsp_type drive_expected[$];
   int unsigned mismatch_count  = 0;
   int unsigned cycle_count     = 0;
   int unsigned hold_off_cycles = 0;
   bit          steady          = 1'b0;

   gain_scheduled_pid_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected drive for one request beat; updates the local state
   function automatic gpid_pkg::rsp_type predict_drive(gpid_pkg::req_type beat);
      gpid_pkg::rsp_type res;
      longint  e, mag, kp, delta, sum, lim_i, total, lim, drive;
      res.drive   = '0;
      res.clamped = 1'b0;
      if (beat.action == ACT_CLEAR) begin
         integral_acc = 0;
         held_error   = 0;
         return res;
      end
      e   = longint'(beat.error_in);
      mag = (e < 0) ? -e : e;

      // scheduled Kp, interpolation truncates toward zero
      if (mag >= longint'(gpid_pkg::MAG_HI)) begin
         kp = longint'(kp_large_q);
      end else if (mag <= longint'(gpid_pkg::MAG_LO)) begin
         kp = longint'(kp_small_q);
      end else begin
         delta = longint'(kp_large_q) - longint'(kp_small_q);
         kp = longint'(kp_small_q)
            + ((mag - longint'(gpid_pkg::MAG_LO)) * delta)
              / (longint'(gpid_pkg::MAG_HI) - longint'(gpid_pkg::MAG_LO));
      end

      // integral separation, then clamp
      sum = integral_acc;
      if (mag < longint'(integrate_below_q)) sum = sum + e;
      lim_i = longint'(integral_clamp_q);
      if (sum > lim_i) sum = lim_i;
      if (sum < -lim_i) sum = -lim_i;
      integral_acc = sum;

      // exact sum, floor shift, output clamp
      total = kp * e + longint'(ki_gain_q) * sum + longint'(kd_gain_q) * (e - held_error);
      drive = total >>> gpid_pkg::FRAC_BITS;
      lim   = longint'(output_clamp_q);
      if (drive > lim) begin
         drive       = lim;
         res.clamped = 1'b1;
      end
      if (drive < -lim) begin
         drive       = -lim;
         res.clamped = 1'b1;
      end
      held_error = e;
      res.drive  = gpid_pkg::DRIVE_W'(drive);
      return res;
   endfunction

   // idle length between beats: mostly short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned pick_stall();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // one register write; the extra edge keeps write enable from toggling in one step
   task automatic write_csr(input logic [gpid_pkg::CSR_IDX_W-1:0] index,
                            input logic [gpid_pkg::CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      unique case (index)
         gpid_pkg::CSR_KP_SMALL:       kp_small_q       = value[gpid_pkg::GAIN_W-1:0];
         gpid_pkg::CSR_KP_LARGE:       kp_large_q       = value[gpid_pkg::GAIN_W-1:0];
         gpid_pkg::CSR_KI_GAIN:        ki_gain_q        = value[gpid_pkg::GAIN_W-1:0];
         gpid_pkg::CSR_KD_GAIN:        kd_gain_q        = value[gpid_pkg::GAIN_W-1:0];
         gpid_pkg::CSR_INTEGRAL_CLAMP: integral_clamp_q = value[gpid_pkg::CLAMP_W-1:0];
         gpid_pkg::CSR_OUTPUT_CLAMP:   output_clamp_q   = value[gpid_pkg::CLAMP_W-1:0];
         gpid_pkg::CSR_INTEGRATE_BELOW:
            integrate_below_q = value[gpid_pkg::THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_gains(input logic [gpid_pkg::GAIN_W-1:0] kps,
                            input logic [gpid_pkg::GAIN_W-1:0] kpl,
                            input logic [gpid_pkg::GAIN_W-1:0] ki,
                            input logic [gpid_pkg::GAIN_W-1:0] kd,
                            input logic [gpid_pkg::CLAMP_W-1:0] iclamp,
                            input logic [gpid_pkg::CLAMP_W-1:0] oclamp,
                            input logic [gpid_pkg::THR_W-1:0] ithr);
      write_csr(gpid_pkg::CSR_KP_SMALL, gpid_pkg::CSR_DATA_W'(kps));
      write_csr(gpid_pkg::CSR_KP_LARGE, gpid_pkg::CSR_DATA_W'(kpl));
      write_csr(gpid_pkg::CSR_KI_GAIN, gpid_pkg::CSR_DATA_W'(ki));
      write_csr(gpid_pkg::CSR_KD_GAIN, gpid_pkg::CSR_DATA_W'(kd));
      write_csr(gpid_pkg::CSR_INTEGRAL_CLAMP, iclamp);
      write_csr(gpid_pkg::CSR_OUTPUT_CLAMP, oclamp);
      write_csr(gpid_pkg::CSR_INTEGRATE_BELOW, gpid_pkg::CSR_DATA_W'(ithr));
   endtask

   // offer one beat until taken, record its expected response, then maybe idle
   task automatic send_beat(input logic action,
                            input logic signed [gpid_pkg::ERR_W-1:0] err);
      gpid_pkg::req_type beat;
      int unsigned       pause;
      beat.action   = action;
      beat.error_in = err;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      drive_expected.push_back(predict_drive(beat));
      pause = steady ? 0 : pick_gap();
      if (pause != 0) begin
         // junk on the bus while not valid
         req_valid <= 1'b0;
         req_data  <= gpid_pkg::req_type'($urandom);
         repeat (pause) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (drive_expected.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // reset gains; breakpoints, their neighbors and the field extremes
   task automatic test_default_gains();
      send_beat(ACT_STEP, 16'sd0);
      send_beat(ACT_STEP, 16'sd512);
      send_beat(ACT_STEP, -16'sd513);
      send_beat(ACT_STEP, 16'sd700);
      send_beat(ACT_STEP, 16'sd895);
      send_beat(ACT_STEP, -16'sd896);
      send_beat(ACT_STEP, 16'sh7FFF);
      send_beat(ACT_STEP, 16'sh8000);
      drain_responses();
   endtask

   // integral and derivative build up, clear wipes both
   task automatic test_clear_action();
      set_gains(gpid_pkg::KP_SMALL_RST, gpid_pkg::KP_LARGE_RST, 16'd256, 16'd256,
                gpid_pkg::INTEGRAL_CLAMP_RST, gpid_pkg::OUTPUT_CLAMP_RST, 15'd1024);
      send_beat(ACT_STEP, 16'sd600);
      send_beat(ACT_STEP, 16'sd2000);
      send_beat(ACT_CLEAR, -16'sd1);
      send_beat(ACT_STEP, -16'sd600);
      send_beat(ACT_STEP, 16'sd300);
      drain_responses();
   endtask

   // all-zero thresholds and clamps, then everything at its maximum
   task automatic test_config_extremes();
      set_gains(GAIN_MAX, '0, GAIN_MAX, GAIN_MAX, '0, '0, '0);
      send_beat(ACT_STEP, 16'sd0);
      send_beat(ACT_STEP, 16'sd700);
      send_beat(ACT_STEP, 16'sh8000);
      drain_responses();
      set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, CLAMP_MAX, CLAMP_MAX, THR_MAX);
      write_csr(CSR_UNUSED_INDEX, '1);
      send_beat(ACT_STEP, 16'sh7FFF);
      send_beat(ACT_STEP, 16'sh7FFF);
      send_beat(ACT_STEP, 16'sh8000);
      drain_responses();
   endtask

   // sum landing exactly on the output limit, and floor rounding of negatives
   task automatic test_limit_and_rounding();
      set_gains(16'd256, 16'd256, '0, '0, CLAMP_MAX, 23'd256, THR_MAX);
      send_beat(ACT_STEP, 16'sd256);
      send_beat(ACT_STEP, 16'sd257);
      send_beat(ACT_STEP, -16'sd256);
      send_beat(ACT_STEP, -16'sd257);
      drain_responses();
      set_gains(16'd1, 16'd1, '0, '0, CLAMP_MAX, CLAMP_MAX, THR_MAX);
      send_beat(ACT_STEP, -16'sd1);
      send_beat(ACT_STEP, 16'sd255);
      drain_responses();
   endtask

   // receiver holds off a long stretch while beats keep coming
   task automatic test_backpressure();
      set_gains(gpid_pkg::KP_SMALL_RST, gpid_pkg::KP_LARGE_RST, 16'd64, 16'd128,
                23'd100000, 23'd4000000, 15'd2000);
      steady = 1'b1;
      hold_off_cycles = HOLD_OFF_LEN;
      repeat (24) send_beat(ACT_STEP, gpid_pkg::ERR_W'($urandom_range(0, 4000) - 2000));
      drain_responses();
      steady = 1'b0;
   endtask

   function automatic logic [gpid_pkg::CLAMP_W-1:0] pick_clamp();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return CLAMP_MAX;
      if (roll < 60) return gpid_pkg::CLAMP_W'($urandom);
      return gpid_pkg::CLAMP_W'($urandom_range(0, 4095));
   endfunction

   function automatic logic [gpid_pkg::GAIN_W-1:0] pick_gain();
      if ($urandom_range(0, 1) == 0) return gpid_pkg::GAIN_W'($urandom);
      return gpid_pkg::GAIN_W'($urandom_range(0, 1024));
   endfunction

   // random settings per phase, steps around the breakpoints, occasional clears
   task automatic test_random_phases();
      int unsigned roll;
      int          err;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         unique case (phase)
            1: set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
                         CLAMP_MAX, CLAMP_MAX, THR_MAX);
            2: set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), '0, '0, '0);
            default: set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                               pick_clamp(), pick_clamp(),
                               ($urandom_range(0, 1) == 0)
                                  ? gpid_pkg::THR_W'($urandom)
                                  : gpid_pkg::THR_W'($urandom_range(0, 2048)));
         endcase
         steady = (phase == 3);
         repeat (PHASE_BEATS) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               send_beat(ACT_CLEAR, gpid_pkg::ERR_W'($urandom));
            end else begin
               if (roll < 45) begin
                  err = $urandom_range(300, 1100);
                  if ($urandom_range(0, 1) == 1) err = -err;
               end else if (roll < 75) begin
                  err = int'($urandom_range(0, 4000)) - 2000;
               end else begin
                  err = int'($urandom);
               end
               send_beat(ACT_STEP, gpid_pkg::ERR_W'(err));
            end
         end
         drain_responses();
         steady = 1'b0;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      gpid_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expected.size() == 0) begin
            $error("unexpected response beat: drive %0d clamped %0b",
                   rsp_data.drive, rsp_data.clamped);
            mismatch_count++;
         end else begin
            want = drive_expected.pop_front();
            if (rsp_data.drive !== want.drive) begin
               $error("drive: expected %0d, actual %0d", want.drive, rsp_data.drive);
               mismatch_count++;
            end
            if (rsp_data.clamped !== want.clamped) begin
               $error("clamped: expected %0b, actual %0b", want.clamped, rsp_data.clamped);
               mismatch_count++;
            end
         end
      end
   end

   // receiver: random stalls, or a long counted hold-off on request
   initial begin
      int unsigned stretch;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            stretch = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (stretch) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!steady && $urandom_range(0, 99) < 15) begin
            rsp_stall <= 1'b1;
            repeat (pick_stall()) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data  = '0;

      // model state after reset
      kp_small_q        = gpid_pkg::KP_SMALL_RST;
      kp_large_q        = gpid_pkg::KP_LARGE_RST;
      ki_gain_q         = '0;
      kd_gain_q         = '0;
      integral_clamp_q  = gpid_pkg::INTEGRAL_CLAMP_RST;
      output_clamp_q    = gpid_pkg::OUTPUT_CLAMP_RST;
      integrate_below_q = gpid_pkg::INTEGRATE_BELOW_RST;
      integral_acc      = 0;
      held_error        = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_default_gains();
      test_clear_action();
      test_config_extremes();
      test_limit_and_rounding();
      test_backpressure();
      test_random_phases();

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### gain_scheduled_pid_unit.f
sv/gpid_pkg.sv
sv/gpid_ctrl.sv
sv/gpid_datapath.sv
sv/gain_scheduled_pid_unit.sv
tb/gain_scheduled_pid_unit_tb.sv
